// ===== hdl/tcpos_pkg.sv =====
`default_nettype none
package tcpos_pkg;

    localparam logic [7:0] KIND_END       = 8'd0;
    localparam logic [7:0] KIND_NOP       = 8'd1;
    localparam logic [7:0] KIND_SACK_PERM = 8'd4;
    localparam logic [7:0] KIND_TIMESTAMP = 8'd8;

    localparam logic [2:0] TSVAL_BYTES = 3'd4;

    typedef enum logic [2:0] {
        PH_KIND,
        PH_LEN,
        PH_SKIP,
        PH_TSLEN,
        PH_TSVAL,
        PH_DONE
    } phase_t;

    // first member lands in the highest bits, so status ends up at bit 0
    typedef struct packed {
        logic        ts_truncated;
        logic [31:0] recent_timestamp;
        logic        timestamps_on;
        logic        sack_permitted;
        logic        status;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/tcp_option_search_timestamp.sv =====
`default_nettype none
// A result enters the output buffer (head, or skid if the head is held) on the transfer
// of the byte that ends the option area (last byte, or a transfer with no byte present).
// One byte per cycle while the skid is empty; the parser step is one small state update.
// A two-entry output buffer keeps input flowing while a result waits on the master side.
// Reset (rst_n low, asynchronous): parser back to expecting a kind, kept flags and
// recent timestamp cleared, output buffer empty.
module tcp_option_search_timestamp
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // option_byte[7:0], search_kind[15:8], segment_seq[47:16], syn_flag[48],
    // rcv_next[80:49], zero fill[87:81]
    input  wire logic [87:0] s_tdata,
    input  wire logic        s_tlast,   // last_byte
    input  wire logic        s_tuser,   // byte_present

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[0], sack_permitted[1], timestamps_on[2], recent_timestamp[34:3],
    // ts_truncated[35], zero fill[39:36]
    output logic [39:0]      m_tdata
);
    import tcpos_pkg::*;

    logic [7:0]  in_byte;
    logic [7:0]  in_kind;
    logic [31:0] in_seq;
    logic        in_syn;
    logic [31:0] in_rnext;
    logic        in_present;
    logic        in_last;

    assign in_byte    = s_tdata[7:0];
    assign in_kind    = s_tdata[15:8];
    assign in_seq     = s_tdata[47:16];
    assign in_syn     = s_tdata[48];
    assign in_rnext   = s_tdata[80:49];
    assign in_present = s_tuser;
    assign in_last    = s_tlast;

    phase_t      phase_reg, phase_next, phase_step;
    logic [7:0]  skip_left_reg, skip_left_next, skip_left_step;
    logic        match_reg, match_next, match_step;
    logic [2:0]  tsval_count_reg, tsval_count_next, tsval_count_step;
    logic [31:0] tsval_shift_reg, tsval_shift_next, tsval_shift_step;
    logic [31:0] recent_reg, recent_next;
    logic        sack_reg, sack_next;
    logic        tstamp_reg, tstamp_next;

    logic        head_valid_reg, head_valid_next;
    result_t     head_reg, head_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_reg, skid_next;

    logic        accept;
    logic        area_end;
    logic        push;
    logic        pop;
    result_t     result;

    assign accept   = s_tvalid && s_tready;
    assign area_end = !in_present || in_last;
    assign push     = accept && area_end;
    assign pop      = m_tvalid && m_tready;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {4'b0000, head_reg};

    // one parser step for the byte at the input
    always_comb
    begin
        phase_step       = phase_reg;
        skip_left_step   = skip_left_reg;
        match_step       = match_reg;
        tsval_count_step = tsval_count_reg;
        tsval_shift_step = tsval_shift_reg;
        if (in_present)
        begin
            case (phase_reg)
                PH_KIND:
                begin
                    if (in_byte == KIND_END)
                    begin
                        phase_step = PH_DONE;
                    end
                    else if (in_byte == KIND_NOP)
                    begin
                        phase_step = PH_KIND;
                    end
                    else if (in_byte == in_kind)
                    begin
                        match_step = 1'b1;
                        phase_step = (in_kind == KIND_TIMESTAMP) ? PH_TSLEN : PH_DONE;
                    end
                    else
                    begin
                        phase_step = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (in_byte < 8'd2)
                    begin
                        phase_step = PH_DONE;
                    end
                    else
                    begin
                        skip_left_step = in_byte - 8'd2;
                        phase_step     = (in_byte == 8'd2) ? PH_KIND : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_left_step = skip_left_reg - 8'd1;
                    if (skip_left_reg == 8'd1)
                    begin
                        phase_step = PH_KIND;
                    end
                end
                PH_TSLEN:
                begin
                    tsval_count_step = 3'd0;
                    phase_step       = PH_TSVAL;
                end
                PH_TSVAL:
                begin
                    tsval_shift_step = {tsval_shift_reg[23:0], in_byte};
                    tsval_count_step = tsval_count_reg + 3'd1;
                    if (tsval_count_reg + 3'd1 >= TSVAL_BYTES)
                    begin
                        phase_step = PH_DONE;
                    end
                end
                default:
                begin
                    phase_step = phase_reg;
                end
            endcase
        end
    end

    // end-of-area result and kept connection flags
    always_comb
    begin
        recent_next           = recent_reg;
        sack_next             = sack_reg;
        tstamp_next           = tstamp_reg;
        result.ts_truncated   = 1'b0;
        if (in_kind == KIND_SACK_PERM)
        begin
            sack_next = match_step;
        end
        if (in_kind == KIND_TIMESTAMP)
        begin
            tstamp_next = match_step;
            if (match_step)
            begin
                if (tsval_count_step >= TSVAL_BYTES)
                begin
                    if ((tsval_shift_step >= recent_reg && in_seq <= in_rnext - 32'd1)
                        || in_syn)
                    begin
                        recent_next = tsval_shift_step;
                    end
                end
                else
                begin
                    result.ts_truncated = 1'b1;
                end
            end
        end
        result.status           = !match_step;
        result.sack_permitted   = sack_next;
        result.timestamps_on    = tstamp_next;
        result.recent_timestamp = recent_next;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        skip_left_next   = skip_left_reg;
        match_next       = match_reg;
        tsval_count_next = tsval_count_reg;
        tsval_shift_next = tsval_shift_reg;
        if (accept)
        begin
            if (area_end)
            begin
                phase_next       = PH_KIND;
                skip_left_next   = 8'd0;
                match_next       = 1'b0;
                tsval_count_next = 3'd0;
                tsval_shift_next = 32'd0;
            end
            else
            begin
                phase_next       = phase_step;
                skip_left_next   = skip_left_step;
                match_next       = match_step;
                tsval_count_next = tsval_count_step;
                tsval_shift_next = tsval_shift_step;
            end
        end
    end

    // two-entry output buffer: head drives the master side, skid catches overflow
    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!head_valid_reg || pop)
        begin
            head_valid_next = push;
            if (push)
            begin
                head_next = result;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_KIND;
            skip_left_reg   <= 8'd0;
            match_reg       <= 1'b0;
            tsval_count_reg <= 3'd0;
            tsval_shift_reg <= 32'd0;
            recent_reg      <= 32'd0;
            sack_reg        <= 1'b0;
            tstamp_reg      <= 1'b0;
            head_valid_reg  <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            skip_left_reg   <= skip_left_next;
            match_reg       <= match_next;
            tsval_count_reg <= tsval_count_next;
            tsval_shift_reg <= tsval_shift_next;
            if (push)
            begin
                recent_reg <= recent_next;
                sack_reg   <= sack_next;
                tstamp_reg <= tstamp_next;
            end
            head_valid_reg  <= head_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry held while head is empty");

    a_trunc_is_found: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[35]) |-> !m_tdata[0])
        else $error("truncated timestamp reported as not found");

    a_tsval_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TSVAL || phase_reg == PH_TSLEN) |-> match_reg)
        else $error("collecting TSval without a match");

    a_tsval_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        tsval_count_reg <= TSVAL_BYTES)
        else $error("TSval byte count overran");

    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_left_reg != 8'd0))
        else $error("skip phase with nothing left to skip");

endmodule
`default_nettype wire
